### rtl/lidar_target_follow_pd_assert.svh
// Assertion macros shared by the follower RTL.
// Needs clk and rst_n in the including module's scope.
`ifndef LIDAR_TARGET_FOLLOW_PD_ASSERT_SVH
`define LIDAR_TARGET_FOLLOW_PD_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define LTF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition implies consequence in the following cycle.
`define LTF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Invariant that holds at every edge out of reset.
`define LTF_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

### rtl/ltf_pkg.sv
// Types and constants for the lidar target follower.
// No dependencies; imported by every module of the block.
package ltf_pkg;

  localparam logic [15:0] NEAREST_START = 16'd65000;
  localparam logic [15:0] SECTOR_HIGH   = 16'd30000;
  localparam logic [15:0] SECTOR_LOW    = 16'd6000;
  localparam logic [15:0] HALF_TURN     = 16'd18000;
  localparam logic signed [17:0] FULL_TURN = 18'sd36000;

  // floor(x / 100) == (x * RECIP_M) >> RECIP_SHIFT, exact for x < 2**22
  localparam int unsigned RECIP_SHIFT = 28;
  localparam logic [21:0] RECIP_M     = 22'd2684355;

  typedef struct packed {
    logic        valid;
    logic        scan_end;
    logic [15:0] angle;
    logic [15:0] distance;
  } point_t;

  typedef struct packed {
    logic [15:0] band_min;
    logic [15:0] band_max;
    logic [15:0] keep;
  } band_cfg_t;

  typedef struct packed {
    logic [11:0] akp;
    logic [11:0] akd;
    logic [11:0] dkp;
    logic [11:0] dkd;
  } gain_cfg_t;

  typedef struct packed {
    logic               valid;
    logic               found;
    logic signed [15:0] a_err;
    logic signed [16:0] a_diff;
    logic signed [16:0] d_err;
    logic signed [17:0] d_diff;
  } err_t;

endpackage

### rtl/ltf_scan.sv
// Running nearest-point search and PD error terms for the follower.
// Depends on ltf_pkg and the assertion macro header.
`include "lidar_target_follow_pd_assert.svh"

module ltf_scan import ltf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  point_t    pt,
  input  band_cfg_t cfg,
  output err_t      err_r
);

  logic [15:0]        near_d_r;
  logic [15:0]        near_a_r;
  logic signed [15:0] prev_a_r;
  logic signed [16:0] prev_d_r;

  logic               in_sector;
  logic               take;
  logic [15:0]        cur_d;
  logic [15:0]        cur_a;
  logic               found;
  logic signed [17:0] mapped;
  logic signed [17:0] a_neg;
  logic signed [15:0] a_err;
  logic signed [16:0] d_err;
  err_t               err_nxt;

  always_comb begin
    in_sector = (pt.angle > SECTOR_HIGH) || (pt.angle < SECTOR_LOW);
    take = in_sector && (pt.distance > cfg.band_min) && (pt.distance < cfg.band_max) &&
           (pt.distance < near_d_r);
    cur_d = take ? pt.distance : near_d_r;
    cur_a = take ? pt.angle : near_a_r;
    found = (cur_a != 16'd0);
    // wrap bearings above 180 degrees down by a full turn
    if (cur_a > HALF_TURN) begin
      mapped = $signed({2'b00, cur_a}) - FULL_TURN;
    end else begin
      mapped = $signed({2'b00, cur_a});
    end
    a_neg = -mapped;
    a_err = a_neg[15:0];
    d_err = $signed({1'b0, cfg.keep}) - $signed({1'b0, cur_d});
    err_nxt.valid  = pt.valid && pt.scan_end;
    err_nxt.found  = found;
    err_nxt.a_err  = a_err;
    err_nxt.a_diff = {a_err[15], a_err} - {prev_a_r[15], prev_a_r};
    err_nxt.d_err  = d_err;
    err_nxt.d_diff = {d_err[16], d_err} - {prev_d_r[16], prev_d_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_d_r <= NEAREST_START;
      near_a_r <= 16'd0;
      prev_a_r <= 16'sd0;
      prev_d_r <= 17'sd0;
      err_r    <= '0;
    end else if (adv) begin
      err_r <= err_nxt;
      if (pt.valid) begin
        if (pt.scan_end) begin
          near_d_r <= NEAREST_START;
          near_a_r <= 16'd0;
          if (found) begin
            prev_a_r <= a_err;
            prev_d_r <= d_err;
          end
        end else begin
          near_d_r <= cur_d;
          near_a_r <= cur_a;
        end
      end
    end
  end

  `LTF_ASSERT_NEXT(a_scan_restart, adv && pt.valid && pt.scan_end, (near_d_r == NEAREST_START) && (near_a_r == 16'd0), "search not restarted after end of scan")
  `LTF_ASSERT_ALWAYS(a_near_bound, near_d_r <= NEAREST_START, "nearest distance above start value")
  `LTF_ASSERT_NOW(a_no_target_zero, err_r.valid && !err_r.found, err_r.a_err == 16'sd0, "angle error set without target")

endmodule

### rtl/ltf_pd.sv
// PD arithmetic pipeline: products, sums, scaling and saturation.
// Depends on ltf_pkg; fed by ltf_scan.
module ltf_pd import ltf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  err_t        err,
  input  gain_cfg_t   gain,
  output logic        valid_r,
  output logic        found_r,
  output logic [15:0] fwd_r,
  output logic [15:0] turn_r
);

  // products
  logic               v2_r, f2_r;
  logic signed [28:0] pa_r;
  logic signed [29:0] pad_r;
  logic signed [29:0] pd_r;
  logic signed [30:0] pdd_r;
  logic signed [28:0] pa_nxt;
  logic signed [29:0] pad_nxt;
  logic signed [29:0] pd_nxt;
  logic signed [30:0] pdd_nxt;

  assign pa_nxt  = $signed({1'b0, gain.akp}) * err.a_err;
  assign pad_nxt = $signed({1'b0, gain.akd}) * err.a_diff;
  assign pd_nxt  = $signed({1'b0, gain.dkp}) * err.d_err;
  assign pdd_nxt = $signed({1'b0, gain.dkd}) * err.d_diff;

  // sums, magnitude for the turn path, truncating shift for the speed path
  logic               v3_r, f3_r, tneg3_r;
  logic [21:0]        tx3_r;
  logic [15:0]        fwd3_r;
  logic signed [30:0] an;
  logic signed [31:0] dn;
  logic signed [31:0] dn_adj;
  logic [30:0]        an_abs;
  logic signed [23:0] dq;
  logic signed [24:0] fwd_w;
  logic [15:0]        fwd_nxt;

  always_comb begin
    an     = pa_r + pad_r;
    dn     = pd_r + pdd_r;
    an_abs = an[30] ? 31'(-an) : 31'(an);
    dn_adj = dn + (dn[31] ? 32'sd255 : 32'sd0);
    dq     = dn_adj[31:8];
    fwd_w  = -{dq[23], dq};
    if (fwd_w > 25'sd32767) begin
      fwd_nxt = 16'h7fff;
    end else if (fwd_w < -25'sd32768) begin
      fwd_nxt = 16'h8000;
    end else begin
      fwd_nxt = fwd_w[15:0];
    end
  end

  // divide by 100 through the reciprocal
  logic        v4_r, f4_r, tneg4_r;
  logic [15:0] q4_r;
  logic [15:0] fwd4_r;
  logic [43:0] prod;
  logic [16:0] q_neg;
  logic [15:0] turn_nxt;

  assign prod = tx3_r * RECIP_M;

  always_comb begin
    q_neg = ~{1'b0, q4_r} + 17'd1;
    if (!tneg4_r) begin
      turn_nxt = (q4_r > 16'd32767) ? 16'h7fff : q4_r;
    end else begin
      turn_nxt = (q4_r > 16'd32768) ? 16'h8000 : q_neg[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      valid_r <= 1'b0;
    end else if (adv) begin
      v2_r    <= err.valid;
      v3_r    <= v2_r;
      v4_r    <= v3_r;
      valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f2_r    <= err.found;
      pa_r    <= pa_nxt;
      pad_r   <= pad_nxt;
      pd_r    <= pd_nxt;
      pdd_r   <= pdd_nxt;
      f3_r    <= f2_r;
      tneg3_r <= an[30];
      tx3_r   <= an_abs[29:8];
      fwd3_r  <= fwd_nxt;
      f4_r    <= f3_r;
      tneg4_r <= tneg3_r;
      q4_r    <= prod[RECIP_SHIFT +: 16];
      fwd4_r  <= fwd3_r;
      found_r <= f4_r;
      fwd_r   <= f4_r ? fwd4_r : 16'd0;
      turn_r  <= f4_r ? turn_nxt : 16'd0;
    end
  end

endmodule

### rtl/lidar_target_follow_pd.sv
// Top level of the lidar nearest-point follower with two PD loops.
// Depends on ltf_pkg, ltf_scan, ltf_pd and the assertion macro header.
//
//   channel  direction  payload (lowest bit first)
//   in_      sink       tdata: point_angle, point_distance; tlast: scan_end
//   out_     source     tdata: forward_speed, turn_rate; tuser: target_found
//   cfg_     sink       cfg_index selects register, cfg_wdata low bits written
//
// One point is taken every clock while the output is not stalled; a result
// is carried from the transfer of its end-of-scan point through the input
// register, search/error stage, multiplier stage, sum stage, reciprocal
// stage and output register. Only end-of-scan points make results.
// Reset (rst_n low, synchronous) restores register defaults and restarts
// the search. A stall on out_tready freezes the whole pipeline.
`include "lidar_target_follow_pd_assert.svh"

module lidar_target_follow_pd import ltf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // point stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] point_angle, [31:16] point_distance
  input  logic        in_tlast,   // scan_end
  // command stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] forward_speed, [31:16] turn_rate
  output logic [0:0]  out_tuser,  // [0] target_found
  // register writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam logic [2:0] REG_BAND_MIN = 3'd0;
  localparam logic [2:0] REG_BAND_MAX = 3'd1;
  localparam logic [2:0] REG_KEEP     = 3'd2;
  localparam logic [2:0] REG_ANGLE_KP = 3'd3;
  localparam logic [2:0] REG_ANGLE_KD = 3'd4;
  localparam logic [2:0] REG_DIST_KP  = 3'd5;
  localparam logic [2:0] REG_DIST_KD  = 3'd6;

  band_cfg_t band_r;
  gain_cfg_t gain_r;

  // Hold register values; an index beyond the list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_r.band_min <= 16'd200;
      band_r.band_max <= 16'd1000;
      band_r.keep     <= 16'd350;
      gain_r.akp      <= 12'd768;
      gain_r.akd      <= 12'd256;
      gain_r.dkp      <= 12'd256;
      gain_r.dkd      <= 12'd128;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BAND_MIN: band_r.band_min <= cfg_wdata;
        REG_BAND_MAX: band_r.band_max <= cfg_wdata;
        REG_KEEP:     band_r.keep     <= cfg_wdata;
        REG_ANGLE_KP: gain_r.akp      <= cfg_wdata[11:0];
        REG_ANGLE_KD: gain_r.akd      <= cfg_wdata[11:0];
        REG_DIST_KP:  gain_r.dkp      <= cfg_wdata[11:0];
        REG_DIST_KD:  gain_r.dkd      <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  // Advance the pipeline whenever the output register is empty or drains.
  logic   adv;
  point_t pt_r;

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // Capture each point transfer; a bubble enters when no transfer occurs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_r.valid <= 1'b0;
    end else if (adv) begin
      pt_r.valid <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pt_r.scan_end <= in_tlast;
      pt_r.angle    <= in_tdata[15:0];
      pt_r.distance <= in_tdata[31:16];
    end
  end

  err_t        err;
  logic        res_found;
  logic [15:0] res_fwd;
  logic [15:0] res_turn;

  // Track the nearest front-sector point and form the error terms.
  ltf_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .pt    (pt_r),
    .cfg   (band_r),
    .err_r (err)
  );

  // Run both PD loops; its last stage is the output register.
  ltf_pd u_pd (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .err     (err),
    .gain    (gain_r),
    .valid_r (out_tvalid),
    .found_r (res_found),
    .fwd_r   (res_fwd),
    .turn_r  (res_turn)
  );

  assign out_tdata    = {res_turn, res_fwd};
  assign out_tuser[0] = res_found;

  `LTF_ASSERT_NOW(a_ready_when_empty, !out_tvalid, in_tready, "input blocked with empty output")
  `LTF_ASSERT_NOW(a_zero_without_target, out_tvalid && !out_tuser[0], out_tdata == 32'd0, "commands set without target")
  `LTF_ASSERT_NOW(a_turn_in_range, out_tvalid, (out_tdata[31:16] != 16'h8000) && (out_tdata[31:16] != 16'h7fff), "turn rate reached saturation")

endmodule

### sim/lidar_target_follow_pd_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for lidar_target_follow_pd: point stream in, PD commands out.
// Holds its own scan search and PD predictor in a small scoreboard class.
// Needs only the block's RTL and ltf_pkg.

// Register indexes of the configuration port.
typedef enum logic [2:0] {
  REG_BAND_MIN,
  REG_BAND_MAX,
  REG_KEEP,
  REG_ANGLE_KP,
  REG_ANGLE_KD,
  REG_DIST_KP,
  REG_DIST_KD,
  REG_SPARE
} ltf_reg_e;

typedef struct {
  logic signed [15:0] fwd;
  logic signed [15:0] turn;
  logic               found;
} ltf_cmd_t;

localparam int unsigned NEAR_RESET = 65000;
localparam int unsigned FRONT_HI   = 30000;
localparam int unsigned FRONT_LO   = 6000;
localparam int          TURN_FULL  = 36000;
localparam int          TURN_HALF  = 18000;
localparam longint      GAIN_ONE   = 256;
localparam longint      TURN_DIV   = 25600;  // Q4.8 scale times hundredths per degree

class ltf_scoreboard;
  int unsigned band_min, band_max, keep_dist;
  int unsigned a_kp, a_kd, d_kp, d_kd;
  int unsigned near_dist, near_ang;
  int          prev_aerr, prev_derr;
  ltf_cmd_t    cmd_q[$];
  int unsigned mismatches, checked, targets;

  function new();
    band_min  = 200;
    band_max  = 1000;
    keep_dist = 350;
    a_kp      = 768;
    a_kd      = 256;
    d_kp      = 256;
    d_kd      = 128;
    near_dist = NEAR_RESET;
    near_ang  = 0;
    prev_aerr = 0;
    prev_derr = 0;
  endfunction

  function void set_reg(ltf_reg_e idx, logic [15:0] v);
    case (idx)
      REG_BAND_MIN: band_min  = v;
      REG_BAND_MAX: band_max  = v;
      REG_KEEP:     keep_dist = v;
      REG_ANGLE_KP: a_kp      = v[11:0];
      REG_ANGLE_KD: a_kd      = v[11:0];
      REG_DIST_KP:  d_kp      = v[11:0];
      REG_DIST_KD:  d_kd      = v[11:0];
      default: ;
    endcase
  endfunction

  function int clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  function void note_point(logic [15:0] ang, logic [15:0] dist_mm, logic scan_end);
    ltf_cmd_t c;
    int       mapped, aerr, derr;
    longint   an, dn;
    if ((ang > FRONT_HI || ang < FRONT_LO) && dist_mm > band_min && dist_mm < band_max &&
        dist_mm < near_dist) begin
      near_dist = dist_mm;
      near_ang  = ang;
    end
    if (!scan_end) return;
    c = '{fwd: 16'sd0, turn: 16'sd0, found: 1'b0};
    if (near_ang != 0) begin
      mapped = (near_ang > TURN_HALF) ? int'(near_ang) - TURN_FULL : int'(near_ang);
      aerr   = -mapped;
      derr   = int'(keep_dist) - int'(near_dist);
      an = longint'(a_kp) * aerr + longint'(a_kd) * (longint'(aerr) - prev_aerr);
      dn = longint'(d_kp) * derr + longint'(d_kd) * (longint'(derr) - prev_derr);
      c.turn  = 16'(clamp16(an / TURN_DIV));
      c.fwd   = 16'(clamp16(-(dn / GAIN_ONE)));
      c.found = 1'b1;
      prev_aerr = aerr;
      prev_derr = derr;
    end
    cmd_q.push_back(c);
    near_dist = NEAR_RESET;
    near_ang  = 0;
  endfunction

  function void check_command(logic [31:0] data, logic found);
    ltf_cmd_t e;
    checked++;
    if (cmd_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected command fwd %0d turn %0d found %0b", $time,
                 $signed(data[15:0]), $signed(data[31:16]), found);
      return;
    end
    e = cmd_q.pop_front();
    if (e.found) targets++;
    if (data[15:0] !== e.fwd || data[31:16] !== e.turn || found !== e.found) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"%0t: command mismatch: expected fwd %0d turn %0d found %0b, ",
                  "got fwd %0d turn %0d found %0b"},
                 $time, e.fwd, e.turn, e.found,
                 $signed(data[15:0]), $signed(data[31:16]), found);
    end
  endfunction

  function int pending();
    return cmd_q.size();
  endfunction
endclass

module lidar_target_follow_pd_tb;
  import ltf_pkg::*;

  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 155;
  localparam int LONG_HOLD   = 300;     // receiver hold-off, long enough to back up the pipe
  localparam int SETTLE      = 8;       // pipeline depth plus margin
  localparam int CYCLE_LIMIT = 300000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_we     = 1'b0;
  logic [2:0]  cfg_index  = '0;
  logic [15:0] cfg_wdata  = '0;

  ltf_scoreboard sb;
  int          cycle_count = 0;
  int          hold_left   = 0;
  int          rx_wait     = 0;
  bit          rx_steady   = 1'b0;
  bit          tx_steady   = 1'b0;
  int unsigned cur_bmin    = 200;
  int unsigned cur_bmax    = 1000;
  int unsigned n_points    = 0;
  int unsigned n_scans     = 0;
  int unsigned n_settings  = 1;

  lidar_target_follow_pd dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [15:0] point_angle, [31:16] point_distance
    .in_tlast   (in_tlast),    // scan_end
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [15:0] forward_speed, [31:16] turn_rate
    .out_tuser  (out_tuser),   // [0] target_found
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("lidar_target_follow_pd verification failed");
      $finish;
    end
  end

  // Count down the long hold-off on the command side.
  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // Command receiver: check each transfer, then draw a stall before the next one unless steady.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_command(out_tdata, out_tuser[0]);
      rx_wait = rx_steady ? 0 : $urandom_range(0, 9);
    end else if (rx_wait > 0) begin
      rx_wait = rx_wait - 1;
    end
    out_tready <= (rx_wait == 0) && (hold_left == 0);
  end

  // Offer one point after a random gap (none when steady) and hold it until the block takes it.
  task automatic send_point(input logic [15:0] ang, input logic [15:0] dist_mm,
                            input logic scan_end);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {dist_mm, ang};
    in_tlast  <= scan_end;
    do @(posedge clk); while (!in_tready);
    sb.note_point(ang, dist_mm, scan_end);
    n_points++;
    if (scan_end) n_scans++;
  endtask

  // Drop valid, wait for every pending command, then let the pipe empty of
  // points that produce nothing.
  task automatic wait_for_commands();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write all seven registers plus the unused index. Gain writes carry junk in
  // the upper bits, which the block must mask off.
  task automatic apply_settings(input logic [15:0] bmin, input logic [15:0] bmax,
                                input logic [15:0] keep,
                                input logic [11:0] akp, input logic [11:0] akd,
                                input logic [11:0] dkp, input logic [11:0] dkd);
    logic [15:0] vals [8];
    vals[REG_BAND_MIN] = bmin;
    vals[REG_BAND_MAX] = bmax;
    vals[REG_KEEP]     = keep;
    vals[REG_ANGLE_KP] = {4'($urandom_range(0, 15)), akp};
    vals[REG_ANGLE_KD] = {4'($urandom_range(0, 15)), akd};
    vals[REG_DIST_KP]  = {4'($urandom_range(0, 15)), dkp};
    vals[REG_DIST_KD]  = {4'($urandom_range(0, 15)), dkd};
    vals[REG_SPARE]    = 16'($urandom);
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      cfg_wdata <= vals[i];
      sb.set_reg(ltf_reg_e'(i), vals[i]);
      @(posedge clk);
    end
    cfg_we   <= 1'b0;
    cur_bmin  = bmin;
    cur_bmax  = bmax;
    n_settings++;
  endtask

  function automatic logic [11:0] draw_gain();
    case ($urandom_range(0, 5))
      0: return 12'd0;
      1: return 12'hFFF;
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  // Mostly front-sector bearings and distances around the band, so that scans
  // actually find targets; the rest is anywhere in the field.
  task automatic send_random_point(input int end_odds);
    logic [15:0] ang, dist_mm;
    int          lo, hi, pick;
    pick = $urandom_range(0, 9);
    if (pick < 6)
      ang = $urandom_range(0, 1) ? 16'($urandom_range(30001, 35999))
                                 : 16'($urandom_range(0, 5999));
    else if (pick < 9)
      ang = 16'($urandom_range(0, 35999));
    else
      ang = 16'($urandom);
    lo   = (cur_bmin > 2) ? int'(cur_bmin) - 2 : 0;
    hi   = (cur_bmax < 65533) ? int'(cur_bmax) + 2 : 65535;
    pick = $urandom_range(0, 9);
    if (pick < 6)
      dist_mm = 16'($urandom_range(lo, hi));
    else if (pick < 9)
      dist_mm = 16'($urandom);
    else begin
      case ($urandom_range(0, 3))
        0: dist_mm = 16'd0;
        1: dist_mm = 16'hFFFF;
        2: dist_mm = 16'(cur_bmin);
        default: dist_mm = 16'(cur_bmax);
      endcase
    end
    send_point(ang, dist_mm, $urandom_range(1, end_odds) == 1);
  endtask

  initial begin
    int bmin;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed scans on the reset defaults.
    send_point(16'd0, 16'd0, 1'b1);          // empty scan: all-zero command
    send_point(16'd100, 16'd500, 1'b0);
    send_point(16'd35000, 16'd400, 1'b0);
    send_point(16'd100, 16'd400, 1'b0);      // equal distance: the earlier point wins
    send_point(16'd20000, 16'd300, 1'b1);    // behind the robot: ignored
    send_point(16'd0, 16'd300, 1'b1);        // target dead ahead: zeros, history held
    send_point(16'd30000, 16'd500, 1'b0);    // sector edges are exclusive
    send_point(16'd6000, 16'd500, 1'b0);
    send_point(16'd5999, 16'd600, 1'b1);
    send_point(16'd100, 16'd200, 1'b0);      // band edges are exclusive
    send_point(16'd100, 16'd1000, 1'b0);
    send_point(16'd30001, 16'd999, 1'b0);
    send_point(16'd200, 16'd201, 1'b1);
    send_point(16'hFFFF, 16'd250, 1'b1);     // bearing beyond a full turn

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_for_commands();
      bmin = $urandom_range(0, 1500);
      case (ph)
        0: apply_settings(16'd0, 16'hFFFF, 16'hFFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
        1: apply_settings(16'd0, 16'hFFFF, 16'd0, 12'd0, 12'd0, 12'hFFF, 12'hFFF);
        2: apply_settings(16'hFFFF, 16'd0, 16'($urandom_range(0, 3000)),
                          draw_gain(), draw_gain(), draw_gain(), draw_gain());
        default: apply_settings(16'(bmin),
                                16'(bmin + $urandom_range(0, 3000)),
                                16'($urandom_range(0, 3000)),
                                draw_gain(), draw_gain(), draw_gain(), draw_gain());
      endcase

      if (ph == 0) begin
        // Wide band, top gains: the 65000 start value and negative saturation.
        send_point(16'd35999, 16'd64999, 1'b0);
        send_point(16'd1, 16'd65000, 1'b0);
        send_point(16'd2, 16'hFFFF, 1'b1);
        send_point(16'd18000, 16'd100, 1'b0);
        send_point(16'd30001, 16'd1, 1'b1);
      end

      tx_steady = (ph == 4);
      rx_steady = (ph == 4);
      // Freeze the receiver while the sender keeps pushing short scans.
      if (ph == 3) hold_left <= LONG_HOLD;

      for (int i = 0; i < PHASE_ITEMS; i++)
        send_random_point((ph == 3 && i < 80) ? 2 : 8);
      send_point(16'd100, 16'd500, 1'b1);   // close the last scan of the phase
    end

    wait_for_commands();
    repeat (20) @(posedge clk);

    $display("Covered %0d points in %0d scans over %0d register settings.",
             n_points, n_scans, n_settings);
    $display("Checked %0d commands, %0d with a target, %0d mismatches.",
             sb.checked, sb.targets, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("lidar_target_follow_pd verification clean");
    end else begin
      $display("lidar_target_follow_pd verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/ltf_pkg.sv
rtl/ltf_scan.sv
rtl/ltf_pd.sv
rtl/lidar_target_follow_pd.sv
sim/lidar_target_follow_pd_tb.sv
